@@ rtl/core/color_tag_to_ansi_sgr_unit_assert.svh @@
// assertion macros for the markup converter
`ifndef COLOR_TAG_TO_ANSI_SGR_UNIT_ASSERT_SVH
`define COLOR_TAG_TO_ANSI_SGR_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CTSGR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, checked out of reset
`define CTSGR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

@@ rtl/core/ctsgr_pkg.sv @@
package ctsgr_pkg;

	localparam int SEQ_MAX = 9;
	localparam int CNT_W = $clog2(SEQ_MAX + 1);

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_HASH  = 2'd1,
		MODE_FG    = 2'd2,
		MODE_BG    = 2'd3
	} parse_mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} result_t;

	typedef struct packed {
		parse_mode_t parse_mode;
		logic        underline_on;
		logic        bold_on;
		logic        color_valid;
		logic [3:0]  color_index;
	} attr_state_t;

	typedef logic [SEQ_MAX-1:0][7:0] seq_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} tag_hit_t;

	localparam attr_state_t STATE_RESET = '{
		parse_mode:   MODE_PLAIN,
		underline_on: 1'b0,
		bold_on:      1'b0,
		color_valid:  1'b0,
		color_index:  4'd0
	};

	localparam logic [7:0] CH_ESC    = 8'd27;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_EQUAL  = 8'h3d;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_LOW_M  = 8'h6d;
	localparam logic [7:0] CH_LOW_N  = 8'h6e;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_D0     = 8'h30;
	localparam logic [7:0] CH_D1     = 8'h31;
	localparam logic [7:0] CH_D3     = 8'h33;
	localparam logic [7:0] CH_D4     = 8'h34;
	localparam logic [7:0] CH_D5     = 8'h35;
	localparam logic [7:0] CH_D8     = 8'h38;
	localparam logic [7:0] CH_D9     = 8'h39;

	localparam logic [15:0][7:0] TAG_CHARS = {
		8'h57, 8'h77, 8'h43, 8'h63, 8'h50, 8'h70, 8'h42, 8'h62,
		8'h59, 8'h79, 8'h47, 8'h67, 8'h52, 8'h72, 8'h44, 8'h64
	};

	function automatic tag_hit_t tag_lookup(input logic [7:0] b);
		tag_hit_t r;
		r = '{hit: 1'b0, idx: 4'd0};
		for (int j = 0; j < 16; j++) begin
			if (TAG_CHARS[j] == b) begin
				r.hit = 1'b1;
				r.idx = 4'(j);
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] color_digit(input logic [3:0] idx);
		return CH_D0 + {5'd0, idx[3:1]};
	endfunction

endpackage

@@ rtl/core/ctsgr_step.sv @@
module ctsgr_step import ctsgr_pkg::*; (
	input  attr_state_t      st,
	input  item_t            item,
	output attr_state_t      nxt,
	output seq_t             seq,
	output logic [CNT_W-1:0] cnt
);

	logic [CNT_W-1:0] n;
	logic [7:0]       b;
	tag_hit_t         th;
	logic             cseq;

	assign b  = item.text_byte;
	assign th = tag_lookup(item.text_byte);

	always_comb begin
		nxt  = st;
		seq  = '0;
		n    = '0;
		cseq = 1'b0;
		if (item.end_of_text) begin
			if (st.parse_mode == MODE_HASH) begin
				seq[n] = CH_HASH; n = n + 1'b1;
			end else if (st.parse_mode == MODE_FG || st.parse_mode == MODE_BG) begin
				seq[n] = CH_LOW_M; n = n + 1'b1;
			end
			if (st.color_valid || st.underline_on || st.bold_on) begin
				seq[n] = CH_ESC; n = n + 1'b1;
				seq[n] = CH_LBRACK; n = n + 1'b1;
				seq[n] = CH_D0; n = n + 1'b1;
				seq[n] = CH_LOW_M; n = n + 1'b1;
			end
			seq[n] = CH_ESC; n = n + 1'b1;
			seq[n] = CH_LBRACK; n = n + 1'b1;
			seq[n] = CH_D0; n = n + 1'b1;
			seq[n] = CH_LOW_M; n = n + 1'b1;
			nxt = STATE_RESET;
		end else begin
			case (st.parse_mode)
				MODE_PLAIN: begin
					if (b == CH_HASH) begin
						nxt.parse_mode = MODE_HASH;
					end else begin
						seq[n] = b; n = n + 1'b1;
					end
				end
				MODE_HASH: begin
					nxt.parse_mode = MODE_PLAIN;
					if (b == CH_LOW_U) begin
						seq[n] = CH_ESC; n = n + 1'b1;
						seq[n] = CH_LBRACK; n = n + 1'b1;
						if (st.underline_on) begin
							nxt.underline_on = 1'b0;
							seq[n] = CH_D0; n = n + 1'b1;
							if (st.bold_on) begin
								seq[n] = CH_SEMI; n = n + 1'b1;
								seq[n] = CH_D1; n = n + 1'b1;
							end
							if (st.color_valid) begin
								seq[n] = CH_SEMI; n = n + 1'b1;
								seq[n] = CH_D3; n = n + 1'b1;
								seq[n] = color_digit(st.color_index); n = n + 1'b1;
							end
						end else begin
							nxt.underline_on = 1'b1;
							seq[n] = CH_D4; n = n + 1'b1;
						end
						seq[n] = CH_LOW_M; n = n + 1'b1;
					end else if (b == CH_MINUS || b == CH_EQUAL) begin
						seq[n] = CH_ESC; n = n + 1'b1;
						seq[n] = CH_LBRACK; n = n + 1'b1;
						seq[n] = (b == CH_MINUS) ? CH_D3 : CH_D4; n = n + 1'b1;
						seq[n] = CH_D8; n = n + 1'b1;
						seq[n] = CH_SEMI; n = n + 1'b1;
						seq[n] = CH_D5; n = n + 1'b1;
						seq[n] = CH_SEMI; n = n + 1'b1;
						nxt.parse_mode = (b == CH_MINUS) ? MODE_FG : MODE_BG;
					end else if (b == CH_HASH) begin
						seq[n] = CH_HASH; n = n + 1'b1;
					end else if (b == CH_LOW_N) begin
						nxt.underline_on = 1'b0;
						nxt.bold_on      = 1'b0;
						nxt.color_valid  = 1'b0;
						nxt.color_index  = 4'd0;
						seq[n] = CH_ESC; n = n + 1'b1;
						seq[n] = CH_LBRACK; n = n + 1'b1;
						seq[n] = CH_D0; n = n + 1'b1;
						seq[n] = CH_LOW_M; n = n + 1'b1;
					end else if (th.hit) begin
						if (!(st.color_valid && st.color_index == th.idx)) begin
							cseq = !st.color_valid || (st.color_index[3:1] != th.idx[3:1]);
							seq[n] = CH_ESC; n = n + 1'b1;
							seq[n] = CH_LBRACK; n = n + 1'b1;
							if (st.bold_on && !th.idx[0]) begin
								seq[n] = CH_D0; n = n + 1'b1;
								nxt.bold_on = 1'b0;
								if (st.underline_on) begin
									seq[n] = CH_SEMI; n = n + 1'b1;
									seq[n] = CH_D4; n = n + 1'b1;
								end
								seq[n] = CH_SEMI; n = n + 1'b1;
								cseq = 1'b1;
							end else if (!st.bold_on && th.idx[0]) begin
								seq[n] = CH_D1; n = n + 1'b1;
								nxt.bold_on = 1'b1;
								if (cseq) begin
									seq[n] = CH_SEMI; n = n + 1'b1;
								end
							end
							if (cseq) begin
								seq[n] = CH_D3; n = n + 1'b1;
								seq[n] = color_digit(th.idx); n = n + 1'b1;
							end
							seq[n] = CH_LOW_M; n = n + 1'b1;
							nxt.color_valid = 1'b1;
							nxt.color_index = th.idx;
						end
					end else begin
						// unknown tag: hash, then the byte as text
						seq[n] = CH_HASH; n = n + 1'b1;
						seq[n] = b; n = n + 1'b1;
					end
				end
				MODE_FG, MODE_BG: begin
					if (b >= CH_D0 && b <= CH_D9) begin
						seq[n] = b; n = n + 1'b1;
					end else begin
						nxt.parse_mode = MODE_PLAIN;
						seq[n] = CH_LOW_M; n = n + 1'b1;
						if (b != ((st.parse_mode == MODE_FG) ? CH_MINUS : CH_EQUAL)) begin
							if (b == CH_HASH) begin
								nxt.parse_mode = MODE_HASH;
							end else begin
								seq[n] = b; n = n + 1'b1;
							end
						end
					end
				end
				default: begin
					nxt.parse_mode = MODE_PLAIN;
				end
			endcase
		end
		cnt = n;
	end

endmodule

@@ rtl/core/color_tag_to_ansi_sgr_unit.sv @@
// path: an accepted item passes the input register, then the output shift buffer
// throughput: one transaction per cycle if each yields at most one byte that is taken;
//   a transaction yielding k bytes holds the output shift buffer until all k are taken
// the input register refills while the last buffered byte is being taken
// reset: arst_n clears the parse and attribute state and empties both stages
`include "color_tag_to_ansi_sgr_unit_assert.svh"

module color_tag_to_ansi_sgr_unit import ctsgr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic             s1_valid_q;
	item_t            s1_item_s1;
	attr_state_t      state_q;
	attr_state_t      state_nxt;
	seq_t             seq_new;
	logic [CNT_W-1:0] cnt_new;
	seq_t             buf_q;
	logic [CNT_W-1:0] buf_cnt_q;
	logic             take;
	logic             buf_free;
	logic             s1_go;

	ctsgr_step u_step (
		.st   (state_q),
		.item (s1_item_s1),
		.nxt  (state_nxt),
		.seq  (seq_new),
		.cnt  (cnt_new)
	);

	assign take         = result_valid && result_ready;
	assign buf_free     = (buf_cnt_q == '0) || (buf_cnt_q == CNT_W'(1) && take);
	assign s1_go        = s1_valid_q && buf_free;
	assign item_ready   = !s1_valid_q || buf_free;
	assign result_valid = (buf_cnt_q != '0);
	assign result       = '{out_byte: buf_q[0], run_last: (buf_cnt_q == CNT_W'(1))};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_valid && item_ready) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			s1_item_s1 <= item;
		end
	end

	// parse and attribute state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (s1_go) begin
			state_q <= state_nxt;
		end
	end

	// output shift buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= '0;
		end else if (s1_go) begin
			buf_cnt_q <= cnt_new;
		end else if (take) begin
			buf_cnt_q <= buf_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			buf_q <= seq_new;
		end else if (take) begin
			buf_q <= {8'h00, buf_q[SEQ_MAX-1:1]};
		end
	end

	`CTSGR_ASSERT_NOW(a_cnt_range, 1'b1, buf_cnt_q <= CNT_W'(SEQ_MAX))
	`CTSGR_ASSERT_NEXT(a_run_continues, take && !result.run_last, result_valid)
	`CTSGR_ASSERT_NEXT(a_state_hold, !s1_go, $stable(state_q))
	`CTSGR_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_go, s1_valid_q && $stable(s1_item_s1))

endmodule
